[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ssd_pkg.sv]
// Types, constants and lookup functions for the seven-segment scan driver.
package ssd_pkg;

  localparam int unsigned DIGIT_COUNT = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned VALUE_W     = 14;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned SEG_W       = 7;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 14'd9999;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } ssd_func_e;

  typedef struct packed {
    ssd_func_e          func;
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;
  } ssd_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] digit_code;
    logic [SEG_W-1:0]  segments;
  } ssd_out_t;

  // Word passed from the front end to the back end: digit 0 is the thousands
  // digit of the first value.
  typedef struct packed {
    ssd_func_e                             func;
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   digits;
  } ssd_cmd_t;

  // Segment pattern, bit 6 = a ... bit 0 = g; anything above nine shows nine.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h7E;
      4'd1:    seg = 7'h30;
      4'd2:    seg = 7'h6D;
      4'd3:    seg = 7'h79;
      4'd4:    seg = 7'h33;
      4'd5:    seg = 7'h5B;
      4'd6:    seg = 7'h5F;
      4'd7:    seg = 7'h70;
      4'd8:    seg = 7'h7F;
      default: seg = 7'h7B;
    endcase
    return seg;
  endfunction

  // Digit line select: scan position bits reversed.
  function automatic logic [CODE_W-1:0] sel_code(input logic [POS_W-1:0] pos);
    return {pos[0], pos[1], pos[2]};
  endfunction

endpackage

[rtl/ssd_front.sv]
// Front end: accepts words, saturates the values and splits them into decimal digits.
module ssd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssd_pkg::ssd_in_t  in_word_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output ssd_pkg::ssd_cmd_t push_cmd_o
);

  localparam int unsigned LANES = 2;

  // Reciprocal constants; exact for the saturated ranges involved.
  localparam logic [27:0] RECIP_1000 = 28'd8389;
  localparam logic [15:0] RECIP_100  = 16'd41;
  localparam logic [14:0] RECIP_10   = 15'd205;

  logic [LANES-1:0][13:0] val_sat;
  logic [LANES-1:0][27:0] prod1;
  logic [LANES-1:0][3:0]  thou_d;
  logic [LANES-1:0][13:0] diff1;

  logic [LANES-1:0][15:0] prod2;
  logic [LANES-1:0][3:0]  hund_d;
  logic [LANES-1:0][9:0]  diff2;

  logic [LANES-1:0][14:0] prod3;
  logic [LANES-1:0][3:0]  tens;
  logic [LANES-1:0][6:0]  diff3;

  logic                   s1_valid_q;
  ssd_pkg::ssd_func_e     s1_func_q;
  logic [LANES-1:0][3:0]  s1_thou_q;
  logic [LANES-1:0][9:0]  s1_rem_q;

  logic                   s2_valid_q;
  ssd_pkg::ssd_func_e     s2_func_q;
  logic [LANES-1:0][3:0]  s2_thou_q;
  logic [LANES-1:0][3:0]  s2_hund_q;
  logic [LANES-1:0][6:0]  s2_rem_q;

  logic s1_ready;
  logic s2_ready;
  logic in_fire;

  assign s2_ready   = !s2_valid_q || push_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  assign val_sat[0] = (in_word_i.first_value > ssd_pkg::MAX_VALUE) ?
                      ssd_pkg::MAX_VALUE : in_word_i.first_value;
  assign val_sat[1] = (in_word_i.second_value > ssd_pkg::MAX_VALUE) ?
                      ssd_pkg::MAX_VALUE : in_word_i.second_value;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod1[l]  = 28'(val_sat[l]) * RECIP_1000;
      thou_d[l] = prod1[l][26:23];
      diff1[l]  = val_sat[l] - (14'(thou_d[l]) * 14'd1000);

      prod2[l]  = 16'(s1_rem_q[l]) * RECIP_100;
      hund_d[l] = prod2[l][15:12];
      diff2[l]  = s1_rem_q[l] - (10'(hund_d[l]) * 10'd100);

      prod3[l]  = 15'(s2_rem_q[l]) * RECIP_10;
      tens[l]   = prod3[l][14:11];
      diff3[l]  = s2_rem_q[l] - (7'(tens[l]) * 7'd10);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q <= in_word_i.func;
      for (int l = 0; l < LANES; l++) begin
        s1_thou_q[l] <= thou_d[l];
        s1_rem_q[l]  <= diff1[l][9:0];
      end
    end
    if (s1_valid_q && s2_ready) begin
      s2_func_q <= s1_func_q;
      for (int l = 0; l < LANES; l++) begin
        s2_thou_q[l] <= s1_thou_q[l];
        s2_hund_q[l] <= hund_d[l];
        s2_rem_q[l]  <= diff2[l][6:0];
      end
    end
  end

  assign push_valid_o = s2_valid_q;

  always_comb begin
    push_cmd_o.func = s2_func_q;
    for (int l = 0; l < LANES; l++) begin
      push_cmd_o.digits[4*l]   = s2_thou_q[l];
      push_cmd_o.digits[4*l+1] = s2_hund_q[l];
      push_cmd_o.digits[4*l+2] = tens[l];
      push_cmd_o.digits[4*l+3] = diff3[l][3:0];
    end
  end

endmodule

[rtl/ssd_fifo.sv]
// Short queue of decoded words between the front end and the back end.
module ssd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  ssd_pkg::ssd_cmd_t wr_cmd_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output ssd_pkg::ssd_cmd_t rd_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssd_pkg::ssd_cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              wr_fire;
  logic              rd_fire;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count_q <= count_q + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

[rtl/ssd_back.sv]
// Back end: digit store, scan position and the registered output word.
module ssd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_valid_i,
  output logic              rd_ready_o,
  input  ssd_pkg::ssd_cmd_t rd_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssd_pkg::ssd_out_t out_word_o
);

  logic [ssd_pkg::DIGIT_COUNT-1:0][ssd_pkg::DIGIT_W-1:0] digit_q;
  logic [ssd_pkg::POS_W-1:0] pos_q;
  logic                      out_valid_q;
  ssd_pkg::ssd_out_t         out_word_q;
  logic                      out_free;
  logic                      pop;
  logic                      load_en;
  logic                      tick_en;

  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_ready_o = (rd_cmd_i.func == ssd_pkg::FUNC_LOAD) || out_free;
  assign pop        = rd_valid_i && rd_ready_o;
  assign load_en    = pop && (rd_cmd_i.func == ssd_pkg::FUNC_LOAD);
  assign tick_en    = pop && (rd_cmd_i.func == ssd_pkg::FUNC_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_en) begin
        digit_q <= rd_cmd_i.digits;
      end
      if (tick_en) begin
        pos_q <= (pos_q == ssd_pkg::POS_W'(ssd_pkg::DIGIT_COUNT - 1)) ? '0 : pos_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_en) begin
      out_word_q.digit_code <= ssd_pkg::sel_code(pos_q);
      out_word_q.segments   <= ssd_pkg::seg_pattern(digit_q[pos_q]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/seven_segment_scan_driver_top.sv]
// Top level of the eight-digit multiplexed seven-segment scan driver.
//
//   channel  direction  payload            handshake
//   in       input      ssd_in_t  (29 b)   in_valid_i / in_ready_o
//   out      output     ssd_out_t (10 b)   out_valid_o / out_ready_i
//
// One word per cycle sustained on both channels while out_ready_i stays high; a
// tick word passes through two digit-split stages and then the queue before the
// output register takes it. Loads give no output word.
// Reset clears the digit store, the scan position and all valid flags.
// A stalled output fills the queue and then the split stages before in_ready_o drops.
module seven_segment_scan_driver_top #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssd_pkg::ssd_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssd_pkg::ssd_out_t out_word_o
);

  logic              push_valid;
  logic              push_ready;
  ssd_pkg::ssd_cmd_t push_cmd;
  logic              pop_valid;
  logic              pop_ready;
  ssd_pkg::ssd_cmd_t pop_cmd;

  ssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  ssd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_cmd_i   (push_cmd),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_cmd_o   (pop_cmd)
  );

  ssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (pop_valid),
    .rd_ready_o  (pop_ready),
    .rd_cmd_i    (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

[rtl/ssd_checker.sv]
// Port-level assertions for the scan driver, bound to the top level.
`include "assert_macros.svh"

module ssd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ssd_pkg::ssd_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ssd_pkg::ssd_out_t out_word_o
);

  logic                      seg_legal;
  logic                      out_stall;
  logic                      out_fire;
  logic [ssd_pkg::CODE_W-1:0] code;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_fire  = out_valid_o && out_ready_i;
  assign code      = out_word_o.digit_code;

  assign seg_legal = (out_word_o.segments == 7'h7E) || (out_word_o.segments == 7'h30) ||
                     (out_word_o.segments == 7'h6D) || (out_word_o.segments == 7'h79) ||
                     (out_word_o.segments == 7'h33) || (out_word_o.segments == 7'h5B) ||
                     (out_word_o.segments == 7'h5F) || (out_word_o.segments == 7'h70) ||
                     (out_word_o.segments == 7'h7F) || (out_word_o.segments == 7'h7B);

  `SSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)
  `SSD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_word_o))
  `SSD_ASSERT_IMPL(a_seg_legal, clk_i, rst_ni, out_valid_o, seg_legal)
  `SSD_ASSERT_NEXT(a_code_steps, clk_i, rst_ni, out_fire, !out_valid_o || code != $past(code))

endmodule

bind seven_segment_scan_driver_top ssd_checker u_ssd_checker (.*);
